>>> hdl/bffa_pkg.sv
// Shared types, constants and helper functions for the bitmap first-fit
// block allocator. No dependencies.
`default_nettype none
package bffa_pkg;

	localparam int NUM_POOLS      = 3;
	localparam int DEF_MAX_HEAPS  = 4;
	localparam int DEF_MAX_BLOCKS = 1024;
	localparam int XW             = 31;   // byte offsets, end marks, heap sizes
	localparam int KW             = 15;   // block counters and sweep bounds
	localparam int NW             = 14;   // blocks needed by one request
	localparam int BCW            = 13;   // blocks per heap
	localparam int SHW            = 5;
	localparam int CFW            = 11;

	localparam logic       FN_FREE = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_LIMIT = 2'd1;
	localparam logic [1:0] ST_SIZE  = 2'd2;

	localparam logic [2:0] CFG_DEF_SHIFT = 3'd0;
	localparam logic [2:0] CFG_UPL_SHIFT = 3'd1;
	localparam logic [2:0] CFG_RBK_SHIFT = 3'd2;
	localparam logic [2:0] CFG_DEF_BLKS  = 3'd3;
	localparam logic [2:0] CFG_UPL_BLKS  = 3'd4;
	localparam logic [2:0] CFG_RBK_BLKS  = 3'd5;

	typedef struct packed {
		logic        func;
		logic [1:0]  pool_kind;
		logic [1:0]  heap_id;
		logic [27:0] offset_bytes;
		logic [28:0] size_bytes;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  heap_id_out;
		logic [27:0] offset_out;
		logic [28:0] size_out;
		logic        new_heap;
	} result_t;

	typedef struct packed {
		logic load;
		logic disp;
		logic heap_next;
		logic scan_init;
		logic scan_run;
		logic scan_hit;
		logic mark_run;
		logic open_init;
		logic open_run;
		logic free_run;
		logic fail_limit;
		logic fail_size;
	} cmd_t;

	typedef struct packed {
		logic is_free;
		logic free_ok;
		logic pool_bad;
		logic heap_avail;
		logic heap_fits;
		logic hit;
		logic scan_end;
		logic mark_end;
		logic open_end;
		logic free_end;
		logic oversize;
		logic at_limit;
	} stat_t;

	function automatic logic [SHW-1:0] eff_shift(input logic [SHW-1:0] v);
		logic [SHW-1:0] r;
		r = v;
		if (v < SHW'(16)) r = SHW'(16);
		if (v > SHW'(18)) r = SHW'(18);
		return r;
	endfunction

	function automatic logic [BCW-1:0] eff_blocks(input logic [CFW-1:0] v,
			input logic [BCW-1:0] maxb);
		logic [BCW-1:0] r;
		r = BCW'(v);
		if (v == '0) r = BCW'(1);
		if (BCW'(v) > maxb) r = maxb;
		return r;
	endfunction

	function automatic logic [NW-1:0] calc_need(input logic [28:0] size,
			input logic [SHW-1:0] sh);
		logic [29:0] s;
		s = {1'b0, size} + ((30'd1 << sh) - 30'd1);
		if (size == '0) return NW'(1);
		return NW'(s >> sh);
	endfunction

endpackage
`default_nettype wire

>>> hdl/bffa_ctrl.sv
// Sequencer for the allocator: dispatch, heap walk, bitmap scan and sweeps.
// Depends on bffa_pkg.
`default_nettype none
module bffa_ctrl import bffa_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  stat_t      stat,
	output cmd_t       cmd,
	output logic       busy,
	output logic       done
);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_DISP = 9'b000000010,
		S_HCHK = 9'b000000100,
		S_SCAN = 9'b000001000,
		S_MARK = 9'b000010000,
		S_NEW  = 9'b000100000,
		S_OPEN = 9'b001000000,
		S_FREE = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				cmd.disp = 1'b1;
				if (stat.is_free) begin
					state_d = stat.free_ok ? S_FREE : S_DONE;
				end else if (stat.pool_bad) begin
					cmd.fail_limit = 1'b1;
					state_d        = S_DONE;
				end else begin
					state_d = S_HCHK;
				end
			end
			S_HCHK: begin
				if (!stat.heap_avail) begin
					state_d = S_NEW;
				end else if (stat.heap_fits) begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end else begin
					cmd.heap_next = 1'b1;
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.hit) begin
					cmd.scan_hit = 1'b1;
					state_d      = S_MARK;
				end else if (stat.scan_end) begin
					cmd.heap_next = 1'b1;
					state_d       = S_HCHK;
				end
			end
			S_MARK: begin
				cmd.mark_run = 1'b1;
				if (stat.mark_end) state_d = S_DONE;
			end
			S_NEW: begin
				if (stat.oversize) begin
					cmd.fail_size = 1'b1;
				end else if (stat.at_limit) begin
					cmd.fail_limit = 1'b1;
				end else begin
					cmd.open_init = 1'b1;
				end
				state_d = (stat.oversize || stat.at_limit) ? S_DONE : S_OPEN;
			end
			S_OPEN: begin
				cmd.open_run = 1'b1;
				if (stat.open_end) state_d = S_DONE;
			end
			S_FREE: begin
				cmd.free_run = 1'b1;
				if (stat.free_end) state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule
`default_nettype wire

>>> hdl/bffa_dp.sv
// Datapath: configuration registers, per-heap state, used-block bitmap
// memory, scan and sweep counters, result register. Depends on bffa_pkg.
`default_nettype none
module bffa_dp import bffa_pkg::*; #(
	parameter int MAX_HEAPS  = DEF_MAX_HEAPS,
	parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  item_t               item,
	input  wire logic           cfg_we,
	input  wire logic [2:0]     cfg_idx,
	input  wire logic [CFW-1:0] cfg_data,
	input  cmd_t                cmd,
	output stat_t               stat,
	output result_t             result
);

	localparam int HW  = (MAX_HEAPS > 1) ? $clog2(MAX_HEAPS) : 1;
	localparam int HCW = $clog2(MAX_HEAPS + 1);
	localparam int BKW = $clog2(MAX_BLOCKS);
	localparam int MD  = 4 * (2 ** HW) * (2 ** BKW);

	logic [SHW-1:0] cfg_sh_q [NUM_POOLS];
	logic [CFW-1:0] cfg_nb_q [NUM_POOLS];

	logic [HCW-1:0] open_q   [4];
	logic [XW-1:0]  endm_q   [4][MAX_HEAPS];
	logic [SHW-1:0] hsh_q    [4][MAX_HEAPS];
	logic [BCW-1:0] hnb_q    [4][MAX_HEAPS];

	item_t          req_q;
	logic [HCW-1:0] hcur_q;
	logic [KW-1:0]  k_q, last_q, lim_q, idx_s1, run_q, start_q;
	logic           rv_s1;
	logic [SHW-1:0] sh_q;
	logic [BCW-1:0] nb_q;
	logic [NW-1:0]  need_q;
	logic [XW-1:0]  al_q;
	result_t        res_q;

	logic           map_mem [MD];
	logic           rd_q;
	logic           mem_we, mem_wd;
	logic [1:0]     pc;
	logic [HW-1:0]  hi;

	logic [SHW-1:0] sh_c, sh_e;
	logic [BCW-1:0] nb_c, nb_e;
	logic [NW-1:0]  need_c, need_e;
	logic [XW-1:0]  al_c, al_e;
	logic [KW-1:0]  first_c, cnt_c, fe_c, lim_c, start_new;
	logic [3:0]     hid4, open4, cur4;
	logic           issue;

	assign pc   = (req_q.pool_kind == 2'd3) ? 2'd0 : req_q.pool_kind;
	assign hi   = hcur_q[HW-1:0];
	assign sh_c = hsh_q[req_q.pool_kind][hi];
	assign nb_c = hnb_q[req_q.pool_kind][hi];
	assign need_c = calc_need(req_q.size_bytes, sh_c);
	assign al_c   = XW'(need_c) << sh_c;
	assign sh_e   = eff_shift(cfg_sh_q[pc]);
	assign nb_e   = eff_blocks(cfg_nb_q[pc], BCW'(MAX_BLOCKS));
	assign need_e = calc_need(req_q.size_bytes, sh_e);
	assign al_e   = XW'(need_e) << sh_e;

	assign first_c = KW'(req_q.offset_bytes >> sh_c);
	assign cnt_c   = KW'(req_q.size_bytes >> sh_c);
	assign fe_c    = first_c + cnt_c;
	assign lim_c   = (fe_c < KW'(nb_c)) ? fe_c : KW'(nb_c);

	assign hid4  = 4'(req_q.heap_id);
	assign open4 = 4'(open_q[req_q.pool_kind]);
	assign cur4  = 4'(hcur_q);

	assign start_new = (run_q == '0) ? idx_s1 : start_q;
	assign issue     = cmd.scan_run && (k_q < KW'(nb_q)) && !stat.hit;

	always_comb begin
		stat            = '0;
		stat.is_free    = (req_q.func == FN_FREE);
		stat.pool_bad   = (req_q.pool_kind == 2'd3);
		stat.free_ok    = !stat.pool_bad && (hid4 < open4);
		stat.heap_avail = (cur4 < open4);
		stat.heap_fits  = (endm_q[req_q.pool_kind][hi] + al_c) <= (XW'(nb_c) << sh_c);
		stat.hit        = rv_s1 && !rd_q && ((run_q + KW'(1)) == KW'(need_q));
		stat.scan_end   = !rv_s1 && (k_q >= KW'(nb_q));
		stat.mark_end   = (k_q == last_q);
		stat.open_end   = (k_q == KW'(nb_q) - KW'(1));
		stat.free_end   = (k_q >= lim_q);
		stat.oversize   = (KW'(need_e) > KW'(nb_e)) || (need_e > NW'(MAX_BLOCKS));
		stat.at_limit   = (open4 >= 4'(MAX_HEAPS));
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wd = 1'b0;
		if (cmd.mark_run) begin
			mem_we = 1'b1;
			mem_wd = 1'b1;
		end else if (cmd.open_run) begin
			mem_we = 1'b1;
			mem_wd = (k_q < KW'(need_q));
		end else if (cmd.free_run) begin
			mem_we = (k_q < lim_q);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) map_mem[{req_q.pool_kind, hi, k_q[BKW-1:0]}] <= mem_wd;
		rd_q <= map_mem[{req_q.pool_kind, hi, k_q[BKW-1:0]}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_sh_q[0] <= SHW'(18);
			cfg_sh_q[1] <= SHW'(18);
			cfg_sh_q[2] <= SHW'(17);
			cfg_nb_q[0] <= CFW'(1024);
			cfg_nb_q[1] <= CFW'(512);
			cfg_nb_q[2] <= CFW'(512);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_DEF_SHIFT: cfg_sh_q[0] <= cfg_data[SHW-1:0];
				CFG_UPL_SHIFT: cfg_sh_q[1] <= cfg_data[SHW-1:0];
				CFG_RBK_SHIFT: cfg_sh_q[2] <= cfg_data[SHW-1:0];
				CFG_DEF_BLKS:  cfg_nb_q[0] <= cfg_data;
				CFG_UPL_BLKS:  cfg_nb_q[1] <= cfg_data;
				CFG_RBK_BLKS:  cfg_nb_q[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < 4; p++) begin
				open_q[p] <= '0;
				for (int h = 0; h < MAX_HEAPS; h++) begin
					endm_q[p][h] <= '0;
					hsh_q[p][h]  <= '0;
					hnb_q[p][h]  <= '0;
				end
			end
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= issue;
			if (cmd.disp && stat.is_free && stat.free_ok)
				endm_q[req_q.pool_kind][hi] <= XW'(req_q.offset_bytes);
			if (cmd.scan_hit)
				endm_q[req_q.pool_kind][hi] <= (XW'(start_new) << sh_q) + al_q;
			if (cmd.open_init) begin
				endm_q[req_q.pool_kind][hi] <= al_e;
				hsh_q[req_q.pool_kind][hi]  <= sh_e;
				hnb_q[req_q.pool_kind][hi]  <= nb_e;
				open_q[req_q.pool_kind]     <= open_q[req_q.pool_kind] + HCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= item;
			hcur_q <= (item.func == FN_FREE) ? HCW'(item.heap_id) : '0;
		end
		if (cmd.heap_next) hcur_q <= hcur_q + HCW'(1);
		if (cmd.disp) begin
			k_q   <= first_c;
			lim_q <= lim_c;
			if (stat.is_free)
				res_q <= '{ST_OK, req_q.heap_id, req_q.offset_bytes, req_q.size_bytes, 1'b0};
		end
		if (cmd.scan_init) begin
			k_q    <= '0;
			run_q  <= '0;
			sh_q   <= sh_c;
			nb_q   <= nb_c;
			need_q <= need_c;
			al_q   <= al_c;
		end
		if (issue) begin
			k_q    <= k_q + KW'(1);
			idx_s1 <= k_q;
		end
		if (rv_s1 && cmd.scan_run) begin
			if (rd_q) begin
				run_q <= '0;
			end else begin
				run_q   <= run_q + KW'(1);
				start_q <= start_new;
			end
		end
		if (cmd.scan_hit) begin
			k_q    <= start_new;
			last_q <= idx_s1;
			res_q  <= '{ST_OK, 2'(hcur_q), 28'((XW'(start_new) << sh_q)), al_q[28:0],
				1'b0};
		end
		if (cmd.mark_run || cmd.open_run || cmd.free_run) k_q <= k_q + KW'(1);
		if (cmd.open_init) begin
			k_q    <= '0;
			nb_q   <= nb_e;
			need_q <= need_e;
			res_q  <= '{ST_OK, 2'(hcur_q), 28'd0, al_e[28:0], 1'b1};
		end
		if (cmd.fail_limit) res_q <= '{ST_LIMIT, 2'd0, 28'd0, 29'd0, 1'b0};
		if (cmd.fail_size)  res_q <= '{ST_SIZE, 2'd0, 28'd0, 29'd0, 1'b0};
	end

	assign result = res_q;

endmodule
`default_nettype wire

>>> hdl/bitmap_first_fit_block_allocator.sv
// A free clears one bitmap bit per released block; an allocate scans the
// bitmap of each open heap with room, one bit per cycle through the single
// map port, then sets one bit per claimed block, or opens a heap and writes its map.
// Throughput: one item at a time; a new start is taken once busy falls.
// Reset clears control, heap counts and end marks and restores the config
// defaults; bitmaps need no clearing since a heap's map is rewritten on open.
`default_nettype none
module bitmap_first_fit_block_allocator import bffa_pkg::*; #(
	parameter int MAX_HEAPS  = DEF_MAX_HEAPS,
	parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  item_t               item,
	output logic                done,
	output result_t             result,
	input  wire logic           cfg_we,
	input  wire logic [2:0]     cfg_idx,
	input  wire logic [CFW-1:0] cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	bffa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	bffa_dp #(
		.MAX_HEAPS  (MAX_HEAPS),
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.stat     (stat),
		.result   (result)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted transfer did not raise busy");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held longer than one cycle");
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |-> !result.new_heap && result.size_out == '0)
		else $error("failure result carries allocation data");

endmodule
`default_nettype wire
